// ----- hdl/ssad_pkg.sv -----
// ----------------------------------------------------------------------------
// ssad_pkg
// Shared types and constants for the SAD stereo disparity block.
// ----------------------------------------------------------------------------
package ssad_pkg;

    localparam int MAX_WIDTH_DEF        = 1024;
    localparam int MAX_WINDOW_DEF       = 15;
    localparam int MAX_LEFT_SEARCH_DEF  = 256;
    localparam int MAX_RIGHT_SEARCH_DEF = 64;

    localparam int ROW_LIMIT = 1024;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_SEARCH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_SEARCH = 3'd4;

    typedef struct packed {
        logic [7:0] left_pixel;
        logic [7:0] right_pixel;
    } in_t;

    typedef struct packed {
        logic signed [8:0] disparity;
        logic              no_match;
        logic [9:0]        out_row;
        logic [9:0]        out_col;
        logic              last_result;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTRE,
        ST_CAND,
        ST_READ,
        ST_DRAIN,
        ST_COMPARE,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic accept;
        logic centre_init;
        logic win_init;
        logic win_step;
        logic cand_update;
        logic out_load;
        logic centre_next;
    } cmd_t;

    typedef struct packed {
        logic emit_any;
        logic cand_done;
        logic win_last;
        logic centre_last;
        logic out_taken;
    } status_t;

endpackage

// ----- hdl/stereo_sad_disparity.sv -----
// ----------------------------------------------------------------------------
// stereo_sad_disparity
// SAD block matching disparity over a stereo pixel stream.
// ----------------------------------------------------------------------------
// Left/right pixel pairs arrive in raster order and are kept in MAX_WINDOW
// line stores per image. A pixel that completes no interior centre is
// accepted without a stall. A pixel that completes centres holds the input
// stalled while each centre is searched, window by window for each of the N
// candidate columns, and while its result waits under out_stall. The search
// rate is set by the line store read port, which delivers one window pixel
// pair per cycle to the shared SAD accumulator.
// Results come out in increasing column order, one result per centre.
module stereo_sad_disparity
    import ssad_pkg::*;
#(
    parameter int MAX_WIDTH        = MAX_WIDTH_DEF,
    parameter int MAX_WINDOW       = MAX_WINDOW_DEF,
    parameter int MAX_LEFT_SEARCH  = MAX_LEFT_SEARCH_DEF,
    parameter int MAX_RIGHT_SEARCH = MAX_RIGHT_SEARCH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_t                  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_t                 out_data,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cmd_t    cmd;
    status_t status;

    ssad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ssad_datapath #(
        .MAX_WIDTH        (MAX_WIDTH),
        .MAX_WINDOW       (MAX_WINDOW),
        .MAX_LEFT_SEARCH  (MAX_LEFT_SEARCH),
        .MAX_RIGHT_SEARCH (MAX_RIGHT_SEARCH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ----- hdl/ssad_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssad_ctrl
// Sequencer: request intake, per-centre candidate loop, window scan, result.
// ----------------------------------------------------------------------------
module ssad_ctrl
    import ssad_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.emit_any)
                    begin
                        state_next = ST_CENTRE;
                    end
                end
            end
            ST_CENTRE:
            begin
                cmd.centre_init = 1'b1;
                state_next      = ST_CAND;
            end
            ST_CAND:
            begin
                if (status.cand_done)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_OUTPUT;
                end
                else
                begin
                    cmd.win_init = 1'b1;
                    state_next   = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.win_step = 1'b1;
                if (status.win_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                cmd.cand_update = 1'b1;
                state_next      = ST_CAND;
            end
            ST_OUTPUT:
            begin
                if (status.out_taken)
                begin
                    if (status.centre_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.centre_next = 1'b1;
                        state_next      = ST_CENTRE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/ssad_datapath.sv -----
// ----------------------------------------------------------------------------
// ssad_datapath
// Line stores, raster position, window SAD accumulator and best-match search.
// ----------------------------------------------------------------------------
module ssad_datapath
    import ssad_pkg::*;
#(
    parameter int MAX_WIDTH        = MAX_WIDTH_DEF,
    parameter int MAX_WINDOW       = MAX_WINDOW_DEF,
    parameter int MAX_LEFT_SEARCH  = MAX_LEFT_SEARCH_DEF,
    parameter int MAX_RIGHT_SEARCH = MAX_RIGHT_SEARCH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  in_t                  in_data,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 out_stall,
    output logic                 out_valid,
    output out_t                 out_data,
    input  cmd_t                 cmd,
    output status_t              status
);

    localparam int XW0   = $clog2(MAX_WIDTH + MAX_LEFT_SEARCH + MAX_RIGHT_SEARCH
                                  + MAX_WINDOW + 1) + 1;
    localparam int XW    = (XW0 > CFG_W + 1) ? XW0 : CFG_W + 1;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int SW    = $clog2(MAX_WINDOW);
    localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int SUM_W = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
    localparam int BASE_MAX = (MAX_WINDOW - 1) / 2;

    // configuration
    logic [10:0] image_width_reg;
    logic [10:0] image_height_reg;
    logic [3:0]  window_size_reg;
    logic [7:0]  left_search_reg;
    logic [5:0]  right_search_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 11'd640;
            image_height_reg <= 11'd480;
            window_size_reg  <= 4'd15;
            left_search_reg  <= 8'd64;
            right_search_reg <= 6'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                CFG_WINDOW_SIZE:  window_size_reg  <= cfg_data[3:0];
                CFG_LEFT_SEARCH:  left_search_reg  <= cfg_data[7:0];
                CFG_RIGHT_SEARCH: right_search_reg <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // effective settings
    logic [XW-1:0] w_eff, h_eff, base, twob, ls, rs, d;

    always_comb
    begin
        w_eff = XW'(image_width_reg);
        if (w_eff > XW'(MAX_WIDTH))
        begin
            w_eff = XW'(MAX_WIDTH);
        end
        if (w_eff == '0)
        begin
            w_eff = XW'(1);
        end
        h_eff = XW'(image_height_reg);
        if (h_eff > XW'(ROW_LIMIT))
        begin
            h_eff = XW'(ROW_LIMIT);
        end
        if (h_eff == '0)
        begin
            h_eff = XW'(1);
        end
        base = XW'(window_size_reg[3:1]);
        if (base > XW'(BASE_MAX))
        begin
            base = XW'(BASE_MAX);
        end
        twob = base << 1;
        ls = XW'(left_search_reg);
        if (ls > XW'(MAX_LEFT_SEARCH))
        begin
            ls = XW'(MAX_LEFT_SEARCH);
        end
        rs = XW'(right_search_reg);
        if (rs > XW'(MAX_RIGHT_SEARCH))
        begin
            rs = XW'(MAX_RIGHT_SEARCH);
        end
        d = (rs != '0) ? rs - XW'(1) : '0;
    end

    // raster position
    logic [9:0]    row_count_reg;
    logic [CW-1:0] col_count_reg;
    logic [SW-1:0] row_slot_reg;

    logic [XW-1:0] r, c;
    assign r = XW'(row_count_reg);
    assign c = XW'(col_count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= '0;
            col_count_reg <= '0;
            row_slot_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            if (c + XW'(1) >= w_eff)
            begin
                col_count_reg <= '0;
                if (r + XW'(1) >= h_eff)
                begin
                    row_count_reg <= '0;
                    row_slot_reg  <= '0;
                end
                else
                begin
                    row_count_reg <= row_count_reg + 10'd1;
                    row_slot_reg  <= (row_slot_reg == SW'(MAX_WINDOW - 1))
                                     ? '0 : row_slot_reg + SW'(1);
                end
            end
            else
            begin
                col_count_reg <= col_count_reg + CW'(1);
            end
        end
    end

    // centres caused by this pixel
    logic          emit_any;
    logic [XW-1:0] j_first, j_last, w_last;
    logic          in_frame;

    always_comb
    begin
        in_frame = (r >= twob) && (r < h_eff) && (c < w_eff) && (w_eff > twob);
        w_last   = w_eff - XW'(1) - base;
        if (c < w_eff - XW'(1))
        begin
            emit_any = in_frame && (c >= twob + d);
            j_first  = c - base - d;
            j_last   = j_first;
        end
        else
        begin
            emit_any = in_frame;
            j_first  = (w_last >= base + d) ? w_last - d : base;
            j_last   = w_last;
        end
    end

    logic [XW-1:0] j_reg, j_last_reg;
    logic [9:0]    out_row_reg;
    logic          last_row_reg;
    logic [SW-1:0] ytop_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            j_reg        <= j_first;
            j_last_reg   <= j_last;
            out_row_reg  <= 10'(r - twob);
            last_row_reg <= (r == h_eff - XW'(1));
            ytop_reg     <= (XW'(row_slot_reg) >= twob)
                            ? SW'(XW'(row_slot_reg) - twob)
                            : SW'(XW'(row_slot_reg) + XW'(MAX_WINDOW) - twob);
        end
        else if (cmd.centre_next)
        begin
            j_reg <= j_reg + XW'(1);
        end
    end

    // candidate range
    logic [XW-1:0] k_reg, hi_reg, best_k_reg;
    logic [XW-1:0] lo_calc, hi_calc;
    logic [SUM_W-1:0] best_reg, acc_reg;
    logic          found_reg;

    always_comb
    begin
        lo_calc = (j_reg >= base + ls) ? j_reg - ls : base;
        if (lo_calc > j_reg)
        begin
            lo_calc = j_reg;
        end
        hi_calc = j_reg + rs;
        if (hi_calc > w_eff - base)
        begin
            hi_calc = w_eff - base;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.centre_init)
        begin
            k_reg      <= lo_calc;
            hi_reg     <= hi_calc;
            best_k_reg <= j_reg;
            best_reg   <= '0;
            found_reg  <= 1'b0;
        end
        else if (cmd.cand_update)
        begin
            if (!found_reg || acc_reg < best_reg)
            begin
                best_reg   <= acc_reg;
                best_k_reg <= k_reg;
                found_reg  <= 1'b1;
            end
            k_reg <= k_reg + XW'(1);
        end
    end

    // window scan
    logic [SW-1:0] x_reg, y_reg, yslot_reg;
    logic          x_wrap;

    assign x_wrap = (XW'(x_reg) == twob);

    always_ff @(posedge clk)
    begin
        if (cmd.win_init)
        begin
            x_reg     <= '0;
            y_reg     <= '0;
            yslot_reg <= ytop_reg;
        end
        else if (cmd.win_step)
        begin
            if (x_wrap)
            begin
                x_reg     <= '0;
                y_reg     <= y_reg + SW'(1);
                yslot_reg <= (yslot_reg == SW'(MAX_WINDOW - 1))
                             ? '0 : yslot_reg + SW'(1);
            end
            else
            begin
                x_reg <= x_reg + SW'(1);
            end
        end
    end

    logic [XW-1:0] lcol, rcol;
    logic [AW-1:0] laddr, raddr, waddr;
    logic          wen;

    assign lcol  = j_reg - base + XW'(x_reg);
    assign rcol  = k_reg - base + XW'(x_reg);
    assign laddr = AW'(yslot_reg) * AW'(MAX_WIDTH) + AW'(lcol[CW-1:0]);
    assign raddr = AW'(yslot_reg) * AW'(MAX_WIDTH) + AW'(rcol[CW-1:0]);
    assign waddr = AW'(row_slot_reg) * AW'(MAX_WIDTH) + AW'(col_count_reg);
    assign wen   = cmd.accept && (c < XW'(MAX_WIDTH));

    // line stores
    logic [7:0] lmem [DEPTH];
    logic [7:0] rmem [DEPTH];
    logic [7:0] lrd_reg, rrd_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            lmem[waddr] <= in_data.left_pixel;
        end
        lrd_reg <= lmem[laddr];
    end

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            rmem[waddr] <= in_data.right_pixel;
        end
        rrd_reg <= rmem[raddr];
    end

    logic       rd_valid_reg;
    logic [7:0] adiff;

    assign adiff = (lrd_reg > rrd_reg) ? lrd_reg - rrd_reg : rrd_reg - lrd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.win_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.win_init)
        begin
            acc_reg <= '0;
        end
        else if (rd_valid_reg)
        begin
            acc_reg <= acc_reg + SUM_W'(adiff);
        end
    end

    // result register
    logic out_valid_reg;
    out_t out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg.disparity   <= found_reg ? 9'(best_k_reg - j_reg) : '0;
            out_data_reg.no_match    <= !found_reg;
            out_data_reg.out_row     <= out_row_reg;
            out_data_reg.out_col     <= 10'(j_reg - base);
            out_data_reg.last_result <= last_row_reg && (j_reg == w_last);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign status.emit_any    = emit_any;
    assign status.cand_done   = (k_reg >= hi_reg);
    assign status.win_last    = x_wrap && (XW'(y_reg) == twob);
    assign status.centre_last = (j_reg == j_last_reg);
    assign status.out_taken   = out_valid_reg && !out_stall;

endmodule
